@@ rtl/core/mfde_pkg.sv @@
`timescale 1ns / 1ps

package mfde_pkg;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ARG  = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  // all-ones block size marks an unused walk level
  localparam logic [3:0] BS_UNUSED = 4'hF;

  typedef struct packed {
    logic [21:0] fill_base;
    logic [3:0]  elem_width;
    logic [19:0] dim_one;
    logic [19:0] dim_two;
    logic [19:0] dim_three;
    logic [3:0]  element_stride;
    logic [23:0] row_stride;
    logic [23:0] plane_stride;
  } mfde_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [39:0] descriptor_word;
    logic [33:0] command_word;
  } mfde_rsp_t;

endpackage

@@ rtl/core/memory_fill_descriptor_encoder.sv @@
`timescale 1ns / 1ps

// Channel    | Handshake          | Payload
// -----------+--------------------+-----------------------------------
// command    | start / busy       | cmd : mfde_cmd_t (geometry of one memory)
// result     | done (one cycle)   | rsp : mfde_rsp_t (status, descriptor, count)
//
// One transaction enters per cycle while busy is low; its result sits on rsp
// with done high after three register stages (decode and log2 with the first
// multiplier, second multiplier with stride check, final select into the
// output register).
// Synchronous reset empties the pipeline and holds busy high for the cycle
// after it. The receiver cannot stall, so nothing waits.

module memory_fill_descriptor_encoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mfde_pkg::mfde_cmd_t cmd,
  output logic                done,
  output mfde_pkg::mfde_rsp_t rsp
);

  import mfde_pkg::*;

  function automatic logic [4:0] flog2(input logic [23:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 1; i < 24; i++) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  // ---------------- stage 1: decode, log2, first product ----------------
  logic        accept;
  logic [3:0]  width_w;
  logic [3:0]  width_sel;

  logic        v1;
  logic [21:0] base1;
  logic [1:0]  size1;
  logic [3:0]  width1;
  logic [19:0] d1_1, d2_1, d3_1;
  logic [23:0] s1_1;
  logic [19:0] prod1;
  logic [4:0]  bs1f1, st1_1, bs2_1, st2_1;
  logic        pow2_1, bad1, oned1, twod1, mism1;

  assign accept  = start && !busy;
  assign width_w = (cmd.elem_width == 4'd3 && cmd.element_stride == 4'd4) ? 4'd4
                                                                          : cmd.elem_width;
  // 3D walks keep the given width
  assign width_sel = (cmd.dim_two != 20'd0 && cmd.dim_three != 20'd0) ? cmd.elem_width
                                                                      : width_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      v1   <= 1'b0;
    end else begin
      busy <= 1'b0;
      v1   <= accept;
    end
    base1  <= cmd.fill_base;
    size1  <= 2'(width_sel - 4'd1);
    width1 <= width_w;
    d1_1   <= cmd.dim_one;
    d2_1   <= cmd.dim_two;
    d3_1   <= cmd.dim_three;
    s1_1   <= cmd.row_stride;
    prod1  <= 20'(cmd.dim_one * cmd.dim_two);
    bs1f1  <= flog2({4'd0, cmd.dim_one});
    st1_1  <= flog2(cmd.row_stride);
    bs2_1  <= flog2({4'd0, cmd.dim_two});
    st2_1  <= flog2(cmd.plane_stride);
    pow2_1 <= (cmd.dim_one & (cmd.dim_one - 20'd1)) == 20'd0;
    bad1   <= cmd.elem_width == 4'd0 || cmd.dim_one == 20'd0
              || cmd.element_stride == 4'd0
              || (cmd.dim_two == 20'd0 && cmd.dim_three != 20'd0);
    oned1  <= cmd.dim_two == 20'd0;
    twod1  <= cmd.dim_three == 20'd0;
    mism1  <= cmd.element_stride != width_w;
  end

  // ---------------- stage 2: second product, rounded-up row checks -------
  logic [4:0]  sh1;
  logic        v2;
  logic [21:0] base2;
  logic [1:0]  size2;
  logic [19:0] d1_2, prod2, count3_2, adj2;
  logic [4:0]  bs1f2, st1_2, bs2_2, st2_2;
  logic        pow2_2, bad2, oned2, twod2, mism2, stride_ok2;

  assign sh1 = bs1f1 + 5'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    base2      <= base1;
    size2      <= size1;
    d1_2       <= d1_1;
    prod2      <= prod1;
    count3_2   <= 20'(prod1 * d3_1);
    // count wraps at 20 bits, so only the low row-stride bits matter here
    adj2       <= 20'((d2_1 << sh1) - s1_1[19:0] + d1_1);
    stride_ok2 <= (({20'd0, width1} << sh1) == s1_1);
    bs1f2      <= bs1f1;
    st1_2      <= st1_1;
    bs2_2      <= bs2_1;
    st2_2      <= st2_1;
    pow2_2     <= pow2_1;
    bad2       <= bad1;
    oned2      <= oned1;
    twod2      <= twod1;
    mism2      <= mism1;
  end

  // ---------------- stage 3: select and pack ----------------
  logic [1:0]  status_next;
  logic [3:0]  bs1_f, st1_f, bs2_f, st2_f;
  logic [19:0] count_f;
  logic [4:0]  bs1_up;
  mfde_rsp_t   rsp_next;

  assign bs1_up = pow2_2 ? bs1f2 : bs1f2 + 5'd1;

  always_comb begin
    status_next = ST_OK;
    bs1_f       = BS_UNUSED;
    st1_f       = 4'd0;
    bs2_f       = BS_UNUSED;
    st2_f       = 4'd0;
    count_f     = d1_2;
    if (bad2) begin
      status_next = ST_BAD_ARG;
    end else if (oned2) begin
      if (mism2) status_next = ST_MISMATCH;
    end else if (twod2) begin
      bs1_f   = bs1_up[3:0];
      st1_f   = st1_2[3:0];
      count_f = pow2_2 ? prod2 : adj2;
      if (mism2 || (!pow2_2 && !stride_ok2)) status_next = ST_MISMATCH;
    end else begin
      bs1_f   = bs1_up[3:0];
      st1_f   = st1_2[3:0];
      bs2_f   = bs2_2[3:0];
      st2_f   = st2_2[3:0];
      count_f = count3_2;
    end

    rsp_next.status = status_next;
    if (status_next == ST_OK) begin
      rsp_next.descriptor_word = {st2_f, bs2_f, st1_f, bs1_f, size2, base2};
      rsp_next.command_word    = {count_f, 14'd0};
    end else begin
      rsp_next.descriptor_word = 40'd0;
      rsp_next.command_word    = 34'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
    rsp <= rsp_next;
  end

  // ---------------- checks ----------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("accepted transaction did not complete three cycles later");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_OK |-> rsp.descriptor_word == 40'd0
                                    && rsp.command_word == 34'd0)
    else $error("failed transaction carries non-zero words");

  a_reset_empty: assert property (@(posedge clk)
    busy |=> !done)
    else $error("result delivered straight after reset");

endmodule
